// File: hw/rtl/lfu_pkg.sv
// Shared constants, types and helpers for the LFU cache table.
package lfu_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W   = IDX_W;
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 5;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = 32;

  // Victim search is split into groups; the group winners are registered.
  localparam int GRP      = (CAPACITY >= 4) ? 4 : 1;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lfu_state_t;

  typedef struct packed {
    logic load;    // capture the accepted request
    logic lookup;  // register key matches and group victim winners
    logic commit;  // apply the table update and load the result register
  } lfu_cmd_t;

  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } lfu_stat_t;

  // True when candidate a is a better eviction victim than candidate b:
  // lower use count first, then older (larger rank).
  function automatic logic lfu_better(
    input logic              ok_a,
    input logic [CNT_W-1:0]  cnt_a,
    input logic [RANK_W-1:0] rank_a,
    input logic              ok_b,
    input logic [CNT_W-1:0]  cnt_b,
    input logic [RANK_W-1:0] rank_b
  );
    return ok_a && (!ok_b || (cnt_a < cnt_b) || ((cnt_a == cnt_b) && (rank_a > rank_b)));
  endfunction

endpackage

// File: hw/rtl/lfu_if.sv
// Request and result channel interfaces of the LFU cache table.
interface lfu_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [lfu_pkg::KEY_W-1:0]  key;
  logic signed [lfu_pkg::VAL_W-1:0]  value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [lfu_pkg::VAL_W-1:0]  read_value;
  logic                              evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

// File: hw/rtl/lfu_ctrl.sv
// Sequencer of the LFU cache table: accept, lookup, update.
module lfu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output lfu_pkg::lfu_cmd_t  cmd,
  input  lfu_pkg::lfu_stat_t stat
);

  lfu_pkg::lfu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lfu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lfu_pkg::ST_LOOKUP;
        end
      end
      lfu_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lfu_pkg::ST_UPDATE;
      end
      lfu_pkg::ST_UPDATE: begin
        // commit and take the next request in the same cycle, once the result register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          in_ready   = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = lfu_pkg::ST_LOOKUP;
          end else begin
            state_nxt = lfu_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/lfu_dp.sv
// Entry storage, search, update and result register of the LFU cache table.
module lfu_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfu_pkg::lfu_cmd_t          cmd,
  output lfu_pkg::lfu_stat_t         stat,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                       in_mode,
  input  logic [lfu_pkg::KEY_W-1:0]  in_key,
  input  logic [lfu_pkg::VAL_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                       out_evicted
);

  localparam int N = lfu_pkg::CAPACITY;

  // entry table
  logic [N-1:0]                      valid_r;
  logic [lfu_pkg::KEY_W-1:0]         key_r  [N];
  logic [lfu_pkg::VAL_W-1:0]         val_r  [N];
  logic [lfu_pkg::CNT_W-1:0]         cnt_r  [N];
  logic [lfu_pkg::RANK_W-1:0]        rank_r [N];
  logic [lfu_pkg::RANK_W-1:0]        rank_nxt [N];
  logic [lfu_pkg::OCC_W-1:0]         occ_r;
  logic [lfu_pkg::CAP_W-1:0]         cap_r;

  // captured request
  logic                              req_mode_r;
  logic [lfu_pkg::KEY_W-1:0]         req_key_r;
  logic [lfu_pkg::VAL_W-1:0]         req_val_r;

  // lookup stage
  logic [N-1:0]                      match_c, match_r;
  logic [lfu_pkg::VAL_W-1:0]         rdval_c, rdval_r;
  logic                              part_ok_c   [lfu_pkg::NGRP];
  logic [lfu_pkg::IDX_W-1:0]         part_idx_c  [lfu_pkg::NGRP];
  logic [lfu_pkg::CNT_W-1:0]         part_cnt_c  [lfu_pkg::NGRP];
  logic [lfu_pkg::RANK_W-1:0]        part_rank_c [lfu_pkg::NGRP];
  logic                              part_ok_r   [lfu_pkg::NGRP];
  logic [lfu_pkg::IDX_W-1:0]         part_idx_r  [lfu_pkg::NGRP];
  logic [lfu_pkg::CNT_W-1:0]         part_cnt_r  [lfu_pkg::NGRP];
  logic [lfu_pkg::RANK_W-1:0]        part_rank_r [lfu_pkg::NGRP];

  // update stage
  logic                              found_any, free_any, vic_ok;
  logic [lfu_pkg::IDX_W-1:0]         found_idx, free_idx, vic_idx, tgt_idx;
  logic [lfu_pkg::CNT_W-1:0]         vic_cnt;
  logic [lfu_pkg::RANK_W-1:0]        vic_rank, tgt_rank;
  logic [lfu_pkg::OCC_W-1:0]         cap_eff;
  logic                              is_put, put_off, need_evict;
  logic                              do_touch, do_age, do_ins, do_setval, do_inc;
  logic                              res_hit, res_evict;
  logic [lfu_pkg::VAL_W-1:0]         res_val;

  // result register
  logic                              out_valid_r, out_hit_r, out_evict_r;
  logic [lfu_pkg::VAL_W-1:0]         out_val_r;

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_val_r;
  assign out_evicted    = out_evict_r;

  // ---- lookup: parallel key compare, value select, group victim winners
  always_comb begin
    int idx;
    rdval_c = '0;
    for (int i = 0; i < N; i++) begin
      match_c[i] = valid_r[i] && (key_r[i] == req_key_r);
      rdval_c    = rdval_c | (match_c[i] ? val_r[i] : '0);
    end
    for (int g = 0; g < lfu_pkg::NGRP; g++) begin
      part_ok_c[g]   = 1'b0;
      part_idx_c[g]  = '0;
      part_cnt_c[g]  = '0;
      part_rank_c[g] = '0;
      for (int j = 0; j < lfu_pkg::GRP; j++) begin
        idx = g * lfu_pkg::GRP + j;
        if (idx < N) begin
          if (lfu_pkg::lfu_better(valid_r[idx], cnt_r[idx], rank_r[idx],
                                  part_ok_c[g], part_cnt_c[g], part_rank_c[g])) begin
            part_ok_c[g]   = 1'b1;
            part_idx_c[g]  = lfu_pkg::IDX_W'(idx);
            part_cnt_c[g]  = cnt_r[idx];
            part_rank_c[g] = rank_r[idx];
          end
        end
      end
    end
  end

  // ---- update: pick target, decide action
  always_comb begin
    found_any = |match_r;
    free_any  = ~&valid_r;
    found_idx = '0;
    free_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_r[i]) found_idx = lfu_pkg::IDX_W'(i);
      if (!valid_r[i]) free_idx = lfu_pkg::IDX_W'(i);
    end
    vic_ok   = 1'b0;
    vic_idx  = '0;
    vic_cnt  = '0;
    vic_rank = '0;
    for (int g = 0; g < lfu_pkg::NGRP; g++) begin
      if (lfu_pkg::lfu_better(part_ok_r[g], part_cnt_r[g], part_rank_r[g],
                              vic_ok, vic_cnt, vic_rank)) begin
        vic_ok   = 1'b1;
        vic_idx  = part_idx_r[g];
        vic_cnt  = part_cnt_r[g];
        vic_rank = part_rank_r[g];
      end
    end

    cap_eff    = (int'(cap_r) > N) ? lfu_pkg::OCC_W'(N) : lfu_pkg::OCC_W'(cap_r);
    is_put     = (req_mode_r == lfu_pkg::MODE_PUT);
    put_off    = is_put && (cap_eff == '0);
    need_evict = (occ_r >= cap_eff) || !free_any;
    tgt_idx    = found_any ? found_idx : (need_evict ? vic_idx : free_idx);
    tgt_rank   = rank_r[tgt_idx];

    do_touch  = 1'b0;
    do_age    = 1'b0;
    do_ins    = 1'b0;
    do_setval = 1'b0;
    do_inc    = 1'b0;
    res_hit   = 1'b0;
    res_evict = 1'b0;
    res_val   = '0;
    if (!is_put) begin
      if (found_any) begin
        do_touch = 1'b1;
        do_inc   = 1'b1;
        res_hit  = 1'b1;
        res_val  = rdval_r;
      end else begin
        res_val  = '1;
      end
    end else if (!put_off) begin
      if (found_any) begin
        do_touch  = 1'b1;
        do_inc    = 1'b1;
        do_setval = 1'b1;
        res_hit   = 1'b1;
      end else if (need_evict) begin
        // drop then insert leaves ranks as a touch of the victim slot would
        if (vic_ok) begin
          do_touch  = 1'b1;
          do_ins    = 1'b1;
          res_evict = 1'b1;
        end
      end else begin
        do_age = 1'b1;
        do_ins = 1'b1;
      end
    end

    for (int i = 0; i < N; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch && valid_r[i] && (lfu_pkg::IDX_W'(i) != tgt_idx) && (rank_r[i] < tgt_rank))
        rank_nxt[i] = rank_r[i] + 1'b1;
      if (do_age && valid_r[i])
        rank_nxt[i] = rank_r[i] + 1'b1;
      if ((do_touch || do_ins) && (lfu_pkg::IDX_W'(i) == tgt_idx))
        rank_nxt[i] = '0;
    end
  end

  // ---- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      cap_r       <= lfu_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.commit && do_ins) valid_r[tgt_idx] <= 1'b1;
      if (cmd.commit && do_age) occ_r <= occ_r + 1'b1;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_key_r  <= in_key;
      req_val_r  <= in_value;
    end
    if (cmd.lookup) begin
      match_r <= match_c;
      rdval_r <= rdval_c;
      for (int g = 0; g < lfu_pkg::NGRP; g++) begin
        part_ok_r[g]   <= part_ok_c[g];
        part_idx_r[g]  <= part_idx_c[g];
        part_cnt_r[g]  <= part_cnt_c[g];
        part_rank_r[g] <= part_rank_c[g];
      end
    end
    if (cmd.commit) begin
      for (int i = 0; i < N; i++) rank_r[i] <= rank_nxt[i];
      if (do_ins) key_r[tgt_idx] <= req_key_r;
      if (do_ins || do_setval) val_r[tgt_idx] <= req_val_r;
      if (do_ins) begin
        cnt_r[tgt_idx] <= lfu_pkg::CNT_W'(1);
      end else if (do_inc && (cnt_r[tgt_idx] != lfu_pkg::CNT_MAX)) begin
        cnt_r[tgt_idx] <= cnt_r[tgt_idx] + 1'b1;
      end
      out_hit_r   <= res_hit;
      out_val_r   <= res_val;
      out_evict_r <= res_evict;
    end
  end

  // ---- checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= lfu_pkg::OCC_W'(N))
    else $error("occupancy above table size");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy differs from number of valid entries");

  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(match_r))
    else $error("key held in more than one entry");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_evict) |=> (occ_r == $past(occ_r)))
    else $error("eviction changed occupancy");

endmodule

// File: hw/rtl/lfu_cache_table.sv
// Top level of the LFU cache table: request/result channels, capacity register.
//
// Key-value cache of lfu_pkg::CAPACITY entries held in flip-flops, with
// least-frequently-used replacement and least-recently-used tie break. Each
// request transfer (mode 0 = get, mode 1 = put) yields exactly one result
// transfer: hit, read_value (stored value on a get hit, -1 on a get miss,
// 0 on a put) and evicted. Each request passes through the lookup
// stage (all keys compared in parallel, victim candidates reduced per group
// of four entries and registered) and then the update stage (final victim
// pick and table write). With the result channel draining, a new request is
// taken in the update cycle of the previous one, never while the previous one
// is in the lookup stage. A request to an idle block goes from the idle state
// through the lookup and update states, and out valid rises with the commit
// of its update. The result sits in an output register; a stalled result
// holds the update stage, and requests are taken only in the idle state or in
// an update cycle whose result register is free. cfg_we/cfg_wdata set
// capacity_in_use (reset 16, values above the table size act as the table
// size, 0 turns puts into no-ops); write it only while no request is
// outstanding. Lowering it below the current fill keeps entries; each later
// put miss then evicts one.
module lfu_cache_table (
  input  logic                       clk,
  input  logic                       rst_n,
  lfu_req_if.sink                    in_ch,
  lfu_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);

  lfu_pkg::lfu_cmd_t  cmd;
  lfu_pkg::lfu_stat_t stat;
  logic [lfu_pkg::VAL_W-1:0] rd_value;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lfu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_ch.mode),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_hit        (out_ch.hit),
    .out_read_value (rd_value),
    .out_evicted    (out_ch.evicted)
  );

  assign out_ch.read_value = signed'(rd_value);

endmodule
